// File: hdl/cpos_pkg.sv
// ============================================================================
// cpos_pkg: shared types and constants for closest point on segment
// Field widths, intermediate widths and result codes.
// ============================================================================
package cpos_pkg;

  localparam int CW   = 32;          // coordinate width
  localparam int DW   = CW + 1;      // coordinate difference width
  localparam int PW   = 2 * DW;      // product width
  localparam int SW   = PW + 2;      // dot product sum width
  localparam int PF   = 24;          // fraction bits of t
  localparam int QW   = PF + 2;      // quotient bits kept
  localparam int TW   = QW + 1;      // signed t width
  localparam int TOLW = PF + 1;      // tolerance register width

  localparam logic [TOLW-1:0] TOL_RESET = TOLW'(168);

  localparam logic [1:0] WHERE_INSIDE = 2'd0;
  localparam logic [1:0] WHERE_START  = 2'd1;
  localparam logic [1:0] WHERE_END    = 2'd2;

  typedef logic [2:0][CW-1:0] vec_t;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_y;
    logic signed [CW-1:0] query_z;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] near_x;
    logic signed [CW-1:0] near_y;
    logic signed [CW-1:0] near_z;
    logic [1:0]           where_code;
  } out_t;

  typedef struct packed {
    vec_t       a;
    vec_t       b;
    logic       neg;
    logic       big;
    logic       zero;
    logic       lt;
    logic [1:0] xlo;
  } side_t;

endpackage

// File: hdl/cpos_prep.sv
// ============================================================================
// cpos_prep: differences, products and dot product sums
// Four stages: differences, products, sums, magnitude and range checks.
// ============================================================================
module cpos_prep (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  cpos_pkg::in_t          in_data,
  output logic                   out_vld,
  output logic [cpos_pkg::SW-1:0] out_rem,
  output logic [cpos_pkg::SW-1:0] out_dn,
  output cpos_pkg::side_t        out_side
);
  import cpos_pkg::*;

  typedef logic [2:0][DW-1:0] dvec_t;
  typedef logic [2:0][PW-1:0] pvec_t;

  vec_t  av, bv, qv;
  dvec_t d_nxt, e_nxt, f_nxt;
  dvec_t d1_r, e1_r, f1_r;
  vec_t  a1_r, b1_r, a2_r, b2_r, a3_r, b3_r;
  pvec_t de_nxt, dd_nxt, ee_nxt, ff_nxt;
  pvec_t de2_r, dd2_r, ee2_r, ff2_r;
  logic [SW-1:0] up_nxt, dn_nxt, la_nxt, lb_nxt;
  logic [SW-1:0] up3_r, dn3_r, la3_r, lb3_r;
  logic [SW-1:0] x_abs;
  logic [SW-1:0] rem_nxt, rem4_r, dn4_r;
  side_t side_nxt, side4_r;
  logic v1_r, v2_r, v3_r, v4_r;

  always_comb begin
    av[0] = in_data.start_x; av[1] = in_data.start_y; av[2] = in_data.start_z;
    bv[0] = in_data.end_x;   bv[1] = in_data.end_y;   bv[2] = in_data.end_z;
    qv[0] = in_data.query_x; qv[1] = in_data.query_y; qv[2] = in_data.query_z;
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = DW'($signed({bv[i][CW-1], bv[i]}) - $signed({av[i][CW-1], av[i]}));
      e_nxt[i] = DW'($signed({qv[i][CW-1], qv[i]}) - $signed({av[i][CW-1], av[i]}));
      f_nxt[i] = DW'($signed({qv[i][CW-1], qv[i]}) - $signed({bv[i][CW-1], bv[i]}));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      de_nxt[i] = PW'($signed(d1_r[i]) * $signed(e1_r[i]));
      dd_nxt[i] = PW'($signed(d1_r[i]) * $signed(d1_r[i]));
      ee_nxt[i] = PW'($signed(e1_r[i]) * $signed(e1_r[i]));
      ff_nxt[i] = PW'($signed(f1_r[i]) * $signed(f1_r[i]));
    end
  end

  always_comb begin
    up_nxt = '0; dn_nxt = '0; la_nxt = '0; lb_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      up_nxt = up_nxt + {{(SW-PW){de2_r[i][PW-1]}}, de2_r[i]};
      dn_nxt = dn_nxt + {{(SW-PW){dd2_r[i][PW-1]}}, dd2_r[i]};
      la_nxt = la_nxt + {{(SW-PW){ee2_r[i][PW-1]}}, ee2_r[i]};
      lb_nxt = lb_nxt + {{(SW-PW){ff2_r[i][PW-1]}}, ff2_r[i]};
    end
  end

  always_comb begin
    x_abs         = up3_r[SW-1] ? (~up3_r + SW'(1)) : up3_r;
    side_nxt.a    = a3_r;
    side_nxt.b    = b3_r;
    side_nxt.neg  = up3_r[SW-1];
    side_nxt.big  = ({2'b00, x_abs} >= {dn3_r, 2'b00});
    side_nxt.zero = (dn3_r == '0);
    side_nxt.lt   = (la3_r < lb3_r);
    side_nxt.xlo  = x_abs[1:0];
    rem_nxt       = x_abs >> 2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= d_nxt; e1_r <= e_nxt; f1_r <= f_nxt; a1_r <= av; b1_r <= bv;
      de2_r <= de_nxt; dd2_r <= dd_nxt; ee2_r <= ee_nxt; ff2_r <= ff_nxt;
      a2_r <= a1_r; b2_r <= b1_r;
      up3_r <= up_nxt; dn3_r <= dn_nxt; la3_r <= la_nxt; lb3_r <= lb_nxt;
      a3_r <= a2_r; b3_r <= b2_r;
      rem4_r <= rem_nxt; dn4_r <= dn3_r; side4_r <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  assign out_vld  = v4_r;
  assign out_rem  = rem4_r;
  assign out_dn   = dn4_r;
  assign out_side = side4_r;

endmodule

// File: hdl/cpos_div.sv
// ============================================================================
// cpos_div: pipelined restoring divider for the segment parameter
// Two quotient bits per stage, one subtract-and-compare per bit.
// ============================================================================
module cpos_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [cpos_pkg::SW-1:0] in_rem,
  input  logic [cpos_pkg::SW-1:0] in_dn,
  input  cpos_pkg::side_t         in_side,
  output logic                    out_vld,
  output logic [cpos_pkg::QW-1:0] out_quo,
  output cpos_pkg::side_t         out_side
);
  import cpos_pkg::*;

  localparam int STEPS = 2;
  localparam int NST   = (QW + STEPS - 1) / STEPS;

  logic [SW-1:0] src_rem [NST];
  logic [SW-1:0] src_dn  [NST];
  logic [QW-1:0] src_quo [NST];
  side_t         src_side[NST];
  logic [SW-1:0] rem_nxt [NST];
  logic [QW-1:0] quo_nxt [NST];
  logic [SW-1:0] rem_r   [NST];
  logic [SW-1:0] dn_r    [NST];
  logic [QW-1:0] quo_r   [NST];
  side_t         side_r  [NST];
  logic [NST-1:0] vld_r;

  always_comb begin
    src_rem[0]  = in_rem;
    src_dn[0]   = in_dn;
    src_quo[0]  = '0;
    src_side[0] = in_side;
    for (int s = 1; s < NST; s++) begin
      src_rem[s]  = rem_r[s-1];
      src_dn[s]   = dn_r[s-1];
      src_quo[s]  = quo_r[s-1];
      src_side[s] = side_r[s-1];
    end
  end

  always_comb begin
    int            k;
    logic          nb;
    logic [SW-1:0] r;
    logic [SW-1:0] t;
    logic [QW-1:0] q;
    for (int s = 0; s < NST; s++) begin
      r = src_rem[s];
      q = src_quo[s];
      for (int j = 0; j < STEPS; j++) begin
        k = QW - 1 - (s * STEPS + j);
        if (k >= 0) begin
          nb = (k >= PF) && src_side[s].xlo[(k >= PF) ? (k - PF) : 0];
          t  = {r[SW-2:0], nb};
          if (t >= src_dn[s]) begin
            r    = t - src_dn[s];
            q[k] = 1'b1;
          end else begin
            r = t;
          end
        end
      end
      rem_nxt[s] = r;
      quo_nxt[s] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NST; s++) begin
        rem_r[s]  <= rem_nxt[s];
        quo_r[s]  <= quo_nxt[s];
        dn_r[s]   <= src_dn[s];
        side_r[s] <= src_side[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign out_quo  = quo_r[NST-1];
  assign out_side = side_r[NST-1];

endmodule

// File: hdl/cpos_proj.sv
// ============================================================================
// cpos_proj: range check, projection and endpoint selection
// Signs t, tests it against the tolerance, scales the direction and saturates.
// ============================================================================
module cpos_proj (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [cpos_pkg::QW-1:0]   in_quo,
  input  cpos_pkg::side_t           in_side,
  input  logic [cpos_pkg::TOLW-1:0] tol,
  output logic                      out_vld,
  output cpos_pkg::out_t            out_data
);
  import cpos_pkg::*;

  localparam int MW = TW + DW;
  localparam int AW = MW - PF + 1;
  localparam logic signed [TW:0] ONE = (TW+1)'(1) <<< PF;

  typedef logic [2:0][DW-1:0] dvec_t;
  typedef logic [2:0][MW-1:0] mvec_t;

  logic signed [TW-1:0] t_nxt, t1_r;
  logic signed [TW:0]   tx, epx;
  logic                 inside_nxt, inside1_r, inside2_r;
  dvec_t                d_nxt, d1_r;
  vec_t                 a1_r, b1_r, a2_r, b2_r;
  logic                 zero1_r, lt1_r, zero2_r, lt2_r;
  mvec_t                prod_nxt, prod2_r;
  logic signed [AW-1:0] sum;
  vec_t                 proj;
  out_t                 res_nxt, res_r;
  logic                 v1_r, v2_r, v3_r;

  always_comb begin
    t_nxt      = in_side.neg ? -$signed({1'b0, in_quo}) : $signed({1'b0, in_quo});
    tx         = {t_nxt[TW-1], t_nxt};
    epx        = $signed({{(TW+1-TOLW){1'b0}}, tol});
    inside_nxt = !in_side.big && !in_side.zero && (tx + epx > 0) && (tx < ONE + epx);
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = DW'($signed({in_side.b[i][CW-1], in_side.b[i]})
                   - $signed({in_side.a[i][CW-1], in_side.a[i]}));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = MW'(t1_r * $signed(d1_r[i]));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum = $signed({prod2_r[i][MW-1], prod2_r[i][MW-1:PF]})
          + $signed({{(AW-CW){a2_r[i][CW-1]}}, a2_r[i]});
      if ((&sum[AW-1:CW-1]) || !(|sum[AW-1:CW-1])) begin
        proj[i] = sum[CW-1:0];
      end else begin
        proj[i] = sum[AW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
    if (zero2_r) begin
      res_nxt = '{a2_r[0], a2_r[1], a2_r[2], WHERE_START};
    end else if (inside2_r) begin
      res_nxt = '{proj[0], proj[1], proj[2], WHERE_INSIDE};
    end else if (lt2_r) begin
      res_nxt = '{a2_r[0], a2_r[1], a2_r[2], WHERE_START};
    end else begin
      res_nxt = '{b2_r[0], b2_r[1], b2_r[2], WHERE_END};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t_nxt; inside1_r <= inside_nxt; d1_r <= d_nxt;
      a1_r <= in_side.a; b1_r <= in_side.b; zero1_r <= in_side.zero; lt1_r <= in_side.lt;
      prod2_r <= prod_nxt; inside2_r <= inside1_r;
      a2_r <= a1_r; b2_r <= b1_r; zero2_r <= zero1_r; lt2_r <= lt1_r;
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld; v2_r <= v1_r; v3_r <= v2_r;
    end
  end

  assign out_vld  = v3_r;
  assign out_data = res_r;

endmodule

// File: hdl/closest_point_on_segment.sv
// ============================================================================
// closest_point_on_segment: closest point on a 3-D segment
// Projects a query point onto a segment or picks the nearer endpoint.
// ============================================================================
// The block takes one beat per cycle while the output side does not stall and
// returns one beat per item, in order. The pipeline holds four stages of
// differences, products, sums and magnitude checks, 13 stages of the divider
// that forms t two bits at a time, and three stages of range check, scaling
// and saturation, the last being the output register.
// A stall at the output freezes the whole pipeline in place.
module closest_point_on_segment (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cpos_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cpos_pkg::out_t            out_data,
  input  logic                      cfg_wr_en,
  input  logic [cpos_pkg::TOLW-1:0] cfg_wr_data
);
  import cpos_pkg::*;

  logic            en;
  logic [TOLW-1:0] tol_r;
  logic            prep_vld, div_vld;
  logic [SW-1:0]   prep_rem, prep_dn;
  side_t           prep_side, div_side;
  logic [QW-1:0]   div_quo;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  cpos_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_data  (in_data),
    .out_vld  (prep_vld),
    .out_rem  (prep_rem),
    .out_dn   (prep_dn),
    .out_side (prep_side)
  );

  cpos_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (prep_vld),
    .in_rem   (prep_rem),
    .in_dn    (prep_dn),
    .in_side  (prep_side),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side)
  );

  cpos_proj u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (div_vld),
    .in_quo   (div_quo),
    .in_side  (div_side),
    .tol      (tol_r),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped during stall");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with empty output stage");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(div_quo) && $stable(div_vld))
    else $error("pipeline advanced during stall");

endmodule

// File: verif/closest_point_on_segment_test.sv
// ============================================================================
// closest_point_on_segment_test: self-checking bench for the segment block
// Streams queries through valid/ready with random idling and stalls, predicts
// each closest point and location code in wide integer math, and compares
// results in order. The tolerance register is swept from 0 up to 2^24.
// ============================================================================
module closest_point_on_segment_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cpos_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 30;

  typedef logic signed [127:0] wide_t;

  class point_scoreboard;
    out_t                near_q[$];
    logic [TOLW-1:0]     tolerance;
    int                  mismatches;
    int                  checked;
    int                  inside_hits;
    int                  start_hits;
    int                  end_hits;

    function new();
      tolerance = TOL_RESET;
    endfunction

    function wide_t saturate(wide_t v);
      wide_t hi;
      wide_t lo;
      hi = (wide_t'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function out_t nearest(in_t x);
      wide_t a[3], b[3], q[3], d[3];
      wide_t up, dn, la, lb, e, f, num, quo, t, eps, p;
      logic  neg;
      logic  in_span;
      out_t  r;
      a[0] = x.start_x; a[1] = x.start_y; a[2] = x.start_z;
      b[0] = x.end_x;   b[1] = x.end_y;   b[2] = x.end_z;
      q[0] = x.query_x; q[1] = x.query_y; q[2] = x.query_z;
      up = 0; dn = 0; la = 0; lb = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = b[i] - a[i];
        e = q[i] - a[i];
        f = q[i] - b[i];
        up += d[i] * e;
        dn += d[i] * d[i];
        la += e * e;
        lb += f * f;
      end
      in_span = 1'b0;
      if (dn == 0) begin
        r.near_x = a[0][CW-1:0];
        r.near_y = a[1][CW-1:0];
        r.near_z = a[2][CW-1:0];
        r.where_code = WHERE_START;
        return r;
      end
      neg = up < 0;
      num = (neg ? -up : up) <<< PF;
      quo = num / dn;
      if (quo < (wide_t'(1) <<< 62)) begin
        t = neg ? -quo : quo;
        eps = wide_t'(tolerance);
        if (t > -eps && t < (wide_t'(1) <<< PF) + eps) begin
          in_span = 1'b1;
          p = saturate(((t * d[0]) >>> PF) + a[0]); r.near_x = p[CW-1:0];
          p = saturate(((t * d[1]) >>> PF) + a[1]); r.near_y = p[CW-1:0];
          p = saturate(((t * d[2]) >>> PF) + a[2]); r.near_z = p[CW-1:0];
          r.where_code = WHERE_INSIDE;
        end
      end
      if (!in_span) begin
        if (la < lb) begin
          r.near_x = a[0][CW-1:0]; r.near_y = a[1][CW-1:0]; r.near_z = a[2][CW-1:0];
          r.where_code = WHERE_START;
        end else begin
          r.near_x = b[0][CW-1:0]; r.near_y = b[1][CW-1:0]; r.near_z = b[2][CW-1:0];
          r.where_code = WHERE_END;
        end
      end
      return r;
    endfunction

    function void note_query(in_t x);
      near_q.push_back(nearest(x));
    endfunction

    function void check_point(out_t got);
      out_t want;
      if (near_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: %h", got);
        return;
      end
      want = near_q.pop_front();
      checked++;
      case (want.where_code)
        WHERE_INSIDE: inside_hits++;
        WHERE_START:  start_hits++;
        default:      end_hits++;
      endcase
      if (got.near_x !== want.near_x || got.near_y !== want.near_y ||
          got.near_z !== want.near_z || got.where_code !== want.where_code) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: expected %0d %0d %0d code %0d, got %0d %0d %0d code %0d",
                   checked, want.near_x, want.near_y, want.near_z, want.where_code,
                   got.near_x, got.near_y, got.near_z, got.where_code);
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  in_t             in_data;
  logic            out_valid;
  logic            out_ready;
  out_t            out_data;
  logic            cfg_wr_en;
  logic [TOLW-1:0] cfg_wr_data;

  point_scoreboard sb;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              hold_left;
  int              quiet_cycles;
  int              sent;
  int              tol_writes;

  closest_point_on_segment uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_query(in_data);
      if (out_valid && out_ready) sb.check_point(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", sb.near_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_query(input in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.near_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOLW-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.tolerance = value;
    tol_writes++;
    @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] span(input int bits);
    return CW'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  function automatic in_t make_query(input logic signed [CW-1:0] ax, ay, az, bx, by, bz,
                                     qx, qy, qz);
    in_t x;
    x.start_x = ax; x.start_y = ay; x.start_z = az;
    x.end_x   = bx; x.end_y   = by; x.end_z   = bz;
    x.query_x = qx; x.query_y = qy; x.query_z = qz;
    return x;
  endfunction

  function automatic in_t random_query();
    in_t x;
    int  kind;
    int  k;
    kind = $urandom_range(9);
    x = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom};
    case (kind)
      0, 1: ;
      2, 3, 4, 5: begin
        x.start_x = span(24); x.start_y = span(24); x.start_z = span(24);
        x.end_x = x.start_x + span(20); x.end_y = x.start_y + span(20);
        x.end_z = x.start_z + span(20);
        k = $urandom_range(0, 24) - 4;
        x.query_x = x.start_x + (((x.end_x - x.start_x) * k) >>> 4) + span(6);
        x.query_y = x.start_y + (((x.end_y - x.start_y) * k) >>> 4) + span(6);
        x.query_z = x.start_z + (((x.end_z - x.start_z) * k) >>> 4) + span(6);
      end
      6: begin
        x.end_x = x.start_x; x.end_y = x.start_y; x.end_z = x.start_z;
      end
      7: begin
        x.end_x = x.start_x + span(2); x.end_y = x.start_y + span(2);
        x.end_z = x.start_z + span(2);
      end
      8: begin
        x.start_x = $urandom_range(1) ? 32'h7fff_0000 + span(8) : 32'h8001_0000 + span(8);
        x.end_x   = x.start_x + (x.start_x[CW-1] ? -span(12) : span(12));
        x.start_y = 0; x.end_y = 0; x.start_z = 0; x.end_z = 0;
        x.query_x = x.end_x + (x.end_x - x.start_x) / 8;
        x.query_y = span(4); x.query_z = span(4);
      end
      default: begin
        x.start_x = span(16); x.start_y = span(16); x.start_z = span(16);
        x.end_x = span(16); x.end_y = span(16); x.end_z = span(16);
        case ($urandom_range(2))
          0: begin x.query_x = x.start_x; x.query_y = x.start_y; x.query_z = x.start_z; end
          1: begin x.query_x = x.end_x; x.query_y = x.end_y; x.query_z = x.end_z; end
          default: begin
            x.query_x = (x.start_x + x.end_x) >>> 1;
            x.query_y = (x.start_y + x.end_y) >>> 1;
            x.query_z = (x.start_z + x.end_z) >>> 1;
          end
        endcase
      end
    endcase
    return x;
  endfunction

  task automatic directed_queries();
    logic signed [CW-1:0] mx;
    logic signed [CW-1:0] mn;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    send_query(make_query(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send_query(make_query(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    send_query(make_query(mn, mn, mn, mx, mx, mx, 0, 0, 0));
    send_query(make_query(mx, mx, mx, mn, mn, mn, mx, mn, mx));
    send_query(make_query(mn, mn, mn, mx, mx, mx, mx, mx, mx));
    send_query(make_query(mn, mn, mn, mx, mx, mx, mn, mn, mn));
    send_query(make_query(5, 6, 7, 5, 6, 7, 100, -100, 3));
    send_query(make_query(0, 0, 0, 32'h20000, 0, 0, 32'h10000, 32'h50000, 0));
    send_query(make_query(0, 0, 0, 32'h20000, 0, 0, -32'h10000, 32'h30000, 0));
    send_query(make_query(0, 0, 0, 32'h20000, 0, 0, 32'h30000, -32'h30000, 0));
    send_query(make_query(0, 0, 0, 32'h20000, 0, 0, -1, 0, 0));
    send_query(make_query(0, 0, 0, 32'h20000, 0, 0, 32'h20001, 0, 0));
    send_query(make_query(0, 0, 0, 1, 0, 0, mx, mx, mn));
    send_query(make_query(0, 0, 0, 1, 1, 1, mn, mn, mn));
    send_query(make_query(32'h7fff_0000, 0, 0, mx, 0, 0, mx, 0, 0));
    send_query(make_query(32'h7fff_0000, 0, 0, mx, 0, 0, 32'h7fff_ff00 + 32'h7f, 5, 5));
    send_query(make_query(32'h8000_ffff, 0, 0, mn, 0, 0, mn, 0, 0));
    send_query(make_query(mn, 3, -3, mn, 3, -3, mx, 0, 0));
    send_query(make_query(1, 2, 3, -1, -2, -3, 1, 2, 3));
    send_query(make_query(1, 2, 3, -1, -2, -3, -1, -2, -3));
  endtask

  initial begin
    logic [TOLW-1:0] tol_plan[5];
    int              idle_plan[4];
    int              stall_plan[4];
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    sent = 0;
    tol_writes = 0;
    tol_plan = '{25'd0, 25'd16777216, 25'd168, 25'd1, 25'(1 << 20)};
    idle_plan = '{0, 80, 0, 17};
    stall_plan = '{0, 0, 80, 17};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_queries();
    drain();
    write_tolerance(25'd16777216);
    directed_queries();
    drain();
    write_tolerance(25'd0);
    directed_queries();
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(ph == 4 ? 25'($urandom_range(0, 16777216)) : tol_plan[ph]);
      send_idle_pct  = idle_plan[ph % 4];
      recv_stall_pct = stall_plan[ph % 4];
      for (int n = 0; n < 200; n++) send_query(random_query());
      if (ph == 0) begin
        hold_left = 300;
        for (int n = 0; n < 60; n++) send_query(random_query());
        drain();
        for (int n = 0; n < 20; n++) send_query(random_query());
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < 150; n++) send_query(random_query());
    drain();

    $display("covered %0d queries over %0d tolerance settings and four idle/stall mixes",
             sent, tol_writes + 1);
    $display("results: %0d inside, %0d start, %0d end, %0d mismatches",
             sb.inside_hits, sb.start_hits, sb.end_hits, sb.mismatches);
    if (sb.mismatches == 0 && sb.near_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/cpos_pkg.sv
hdl/cpos_prep.sv
hdl/cpos_div.sv
hdl/cpos_proj.sv
hdl/closest_point_on_segment.sv
verif/closest_point_on_segment_test.sv
